>>> src/i2crm_pkg.sv
// shared constants, operation codes and controller/datapath interface types
// for the i2c target register map; no dependencies
package i2crm_pkg;

    // receive buffer depth and register map limit
    localparam int RX_DEPTH  = 26;
    localparam int MAP_LIMIT = 26;

    // index into the receive buffer and count of buffered bytes
    localparam int IDX_W = $clog2(RX_DEPTH);
    localparam int CNT_W = $clog2(RX_DEPTH + 1);

    // byte returned for unmapped or out-of-range addresses
    localparam logic [7:0] FILLER_BYTE = 8'hAA;

    // register map addresses
    localparam logic [7:0] ADDR_WAKE      = 8'd1;
    localparam logic [7:0] ADDR_OUT_CFG   = 8'd6;
    localparam logic [7:0] ADDR_SECONDS   = 8'd7;
    localparam logic [7:0] ADDR_MINUTES   = 8'd8;
    localparam logic [7:0] ADDR_HOURS     = 8'd9;
    localparam logic [7:0] ADDR_DOW       = 8'd10;
    localparam logic [7:0] ADDR_DOM       = 8'd11;
    localparam logic [7:0] ADDR_MONTH     = 8'd12;
    localparam logic [7:0] ADDR_YEAR_HI   = 8'd13;
    localparam logic [7:0] ADDR_YEAR_LO   = 8'd14;

    // bus event codes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_TX    = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_count;
        logic push_byte;
        logic tx_read;
        logic commit_init;
        logic commit_step;
        logic load_result;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic commit_needed;
        logic commit_last;
    } dp_status_t;

endpackage

>>> src/i2crm_datapath.sv
// datapath: pointer, receive buffer memory, register map and result register
// depends on i2crm_pkg
module i2crm_datapath import i2crm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  s_data_in,
    output dp_status_t  status,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_valid
);

    logic [7:0]       ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] cidx_reg;
    logic [7:0]       buf0_reg;
    logic [7:0]       rx_mem [RX_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] rd_addr;
    logic [CNT_W-1:0] cidx_inc;

    logic [7:0]  wake_reg;
    logic [7:0]  out_cfg_reg;
    logic [7:0]  seconds_reg;
    logic [7:0]  minutes_reg;
    logic [7:0]  hours_reg;
    logic [7:0]  dow_reg;
    logic [7:0]  dom_reg;
    logic [7:0]  month_reg;
    logic [15:0] year_reg;

    logic [7:0]  map_rd;
    logic [7:0]  wr_data;
    logic        map_we;
    logic        buf_full;
    logic        ptr_in_map;

    logic [7:0]  tx_byte_reg;
    logic        tx_valid_reg;

    assign buf_full   = (count_reg == CNT_W'(RX_DEPTH));
    assign ptr_in_map = (ptr_reg < 8'(MAP_LIMIT));
    assign cidx_inc   = cidx_reg + CNT_W'(1);

    // commit progress
    assign status.commit_needed = (count_reg > CNT_W'(1));
    assign status.commit_last   = (cidx_inc == count_reg);

    // register map read at the pointer
    always_comb begin
        unique case (ptr_reg)
            ADDR_WAKE:    map_rd = wake_reg;
            ADDR_OUT_CFG: map_rd = out_cfg_reg;
            ADDR_SECONDS: map_rd = seconds_reg;
            ADDR_MINUTES: map_rd = minutes_reg;
            ADDR_HOURS:   map_rd = hours_reg;
            ADDR_DOW:     map_rd = dow_reg;
            ADDR_DOM:     map_rd = dom_reg;
            ADDR_MONTH:   map_rd = month_reg;
            ADDR_YEAR_HI: map_rd = year_reg[15:8];
            ADDR_YEAR_LO: map_rd = year_reg[7:0];
            default:      map_rd = FILLER_BYTE;
        endcase
    end

    // pointer and receive count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.clear_count) begin
                count_reg <= '0;
            end
            if (cmd.push_byte) begin
                if (!buf_full) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                ptr_reg <= (count_reg == '0) ? s_data_in : buf0_reg;
            end
            if (cmd.tx_read && ptr_in_map) begin
                ptr_reg <= ptr_reg + 8'd1;
            end
            if (cmd.commit_step) begin
                ptr_reg <= ptr_reg + 8'd1;
            end
        end
    end

    // receive buffer writes, first byte kept aside for pointer reloads
    always_ff @(posedge aclk) begin
        if (cmd.push_byte && !buf_full) begin
            rx_mem[count_reg[IDX_W-1:0]] <= s_data_in;
            if (count_reg == '0) begin
                buf0_reg <= s_data_in;
            end
        end
    end

    // commit index and registered buffer read
    assign rd_addr = cmd.commit_init ? CNT_W'(1) : cidx_inc;

    always_ff @(posedge aclk) begin
        if (cmd.commit_init) begin
            cidx_reg <= CNT_W'(1);
        end else if (cmd.commit_step) begin
            cidx_reg <= cidx_inc;
        end
        if ((cmd.commit_init || cmd.commit_step) && rd_addr < CNT_W'(RX_DEPTH)) begin
            rd_data_reg <= rx_mem[rd_addr[IDX_W-1:0]];
        end
    end

    // register map writes during commit
    assign map_we  = cmd.commit_step;
    assign wr_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wake_reg    <= '0;
            out_cfg_reg <= '0;
            seconds_reg <= '0;
            minutes_reg <= '0;
            hours_reg   <= '0;
            dow_reg     <= '0;
            dom_reg     <= '0;
            month_reg   <= '0;
            year_reg    <= '0;
        end else if (map_we) begin
            unique case (ptr_reg)
                ADDR_WAKE:    wake_reg        <= wr_data;
                ADDR_OUT_CFG: out_cfg_reg     <= wr_data;
                ADDR_SECONDS: seconds_reg     <= wr_data;
                ADDR_MINUTES: minutes_reg     <= wr_data;
                ADDR_HOURS:   hours_reg       <= wr_data;
                ADDR_DOW:     dow_reg         <= wr_data;
                ADDR_DOM:     dom_reg         <= wr_data;
                ADDR_MONTH:   month_reg       <= wr_data;
                ADDR_YEAR_HI: year_reg[15:8]  <= wr_data;
                ADDR_YEAR_LO: year_reg[7:0]   <= wr_data;
                default:      ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            tx_byte_reg  <= (cmd.tx_read && ptr_in_map) ? map_rd
                          : (cmd.tx_read ? FILLER_BYTE : 8'd0);
            tx_valid_reg <= cmd.tx_read;
        end
    end

    assign m_tx_byte  = tx_byte_reg;
    assign m_tx_valid = tx_valid_reg;

endmodule

>>> src/i2crm_ctrl.sv
// controller: input/output handshake and the stop commit sequence
// depends on i2crm_pkg
module i2crm_ctrl import i2crm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   accept;
    op_t    op;

    assign op      = op_t'(s_op);
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // command decode
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        if (accept) begin
            unique case (op)
                OP_START: begin
                    cmd.clear_count = 1'b1;
                    cmd.load_result = 1'b1;
                end
                OP_RX: begin
                    cmd.push_byte   = 1'b1;
                    cmd.load_result = 1'b1;
                end
                OP_TX: begin
                    cmd.tx_read     = 1'b1;
                    cmd.load_result = 1'b1;
                end
                OP_STOP: begin
                    if (status.commit_needed) begin
                        cmd.commit_init = 1'b1;
                        state_next      = ST_COMMIT;
                    end else begin
                        cmd.load_result = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == ST_COMMIT) begin
            cmd.commit_step = 1'b1;
            if (status.commit_last) begin
                cmd.load_result = 1'b1;
                state_next      = ST_IDLE;
            end
        end
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // a stop with data bytes enters the commit sequence with no result shown
    a_stop_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_STOP && status.commit_needed)
        |=> (state_reg == ST_COMMIT && !m_valid_reg))
        else $error("stop with data did not enter commit");

    // any other accepted item shows its result in the next cycle
    a_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !(op == OP_STOP && status.commit_needed))
        |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result missing after single-cycle item");

    // commit keeps going until the last buffered byte
    a_commit_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && !status.commit_last) |=> (state_reg == ST_COMMIT))
        else $error("commit ended early");

    // last commit step returns to idle with a result
    a_commit_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT && status.commit_last)
        |=> (state_reg == ST_IDLE && m_valid_reg))
        else $error("commit did not finish with a result");

endmodule

>>> src/i2c_target_register_map.sv
// i2c target register map top level: controller plus datapath
// results: start, received byte, transmit and stop with at most one buffered byte
// show in the next cycle; a stop with data bytes commits one byte per commit step
// throughput: one item per cycle outside commit while m_ready keeps the one-deep
// result register free; a committing stop holds off the input until its last step
// reset: synchronous active-low aresetn clears pointer, count and all map registers
// depends on i2crm_pkg, i2crm_ctrl, i2crm_datapath
module i2c_target_register_map import i2crm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_data_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_tx_valid
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing and handshake
    i2crm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // storage and register map
    i2crm_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_data_in  (s_data_in),
        .status     (status),
        .m_tx_byte  (m_tx_byte),
        .m_tx_valid (m_tx_valid)
    );

endmodule

>>> tb/i2c_target_register_map_test.sv
// testbench for i2c_target_register_map: directed and random bus sessions against
// an in-bench register map predictor, with random idling on both sides and a long receiver stall
// depends on i2crm_pkg and the i2c_target_register_map rtl
module i2c_target_register_map_test;
    import i2crm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one reply of the block
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
    } tx_reply_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_op;
    logic [7:0] s_data_in;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_tx_byte;
    logic       m_tx_valid;

    // predicted map state
    logic [7:0]       map_ptr;
    logic [CNT_W-1:0] rx_fill;
    logic [7:0]       rx_bytes [RX_DEPTH];
    logic [7:0]       clock_regs [16];

    tx_reply_t expected_replies [$];
    tx_reply_t oldest_reply;

    int items_sent;
    int replies_checked;
    int tx_bytes_seen;
    int bytes_committed;
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;

    i2c_target_register_map dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_byte  (m_tx_byte),
        .m_tx_valid (m_tx_valid)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("i2c_target_register_map verification failed");
        $finish;
    end

    // mapped addresses hold a byte, everything else reads as filler
    function automatic bit addr_mapped(input logic [7:0] addr);
        case (addr)
            ADDR_WAKE, ADDR_OUT_CFG, ADDR_SECONDS, ADDR_MINUTES, ADDR_HOURS,
            ADDR_DOW, ADDR_DOM, ADDR_MONTH, ADDR_YEAR_HI, ADDR_YEAR_LO: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // apply one bus event to the predicted map and queue its reply
    function automatic void predict_bus_event(input op_t op, input logic [7:0] data);
        tx_reply_t reply;
        int i;
        reply = '0;
        case (op)
            OP_START: begin
                rx_fill = '0;
            end
            OP_RX: begin
                if (rx_fill < RX_DEPTH) begin
                    rx_bytes[rx_fill] = data;
                    rx_fill = rx_fill + 1'b1;
                end
                map_ptr = rx_bytes[0];
            end
            OP_TX: begin
                reply.tx_valid = 1'b1;
                if (map_ptr < MAP_LIMIT) begin
                    reply.tx_byte = addr_mapped(map_ptr) ? clock_regs[map_ptr[3:0]]
                                                         : FILLER_BYTE;
                    map_ptr = map_ptr + 8'd1;
                end else begin
                    reply.tx_byte = FILLER_BYTE;
                end
            end
            default: begin
                // commit buffered data bytes, pointer wraps at 256
                for (i = 1; i < rx_fill; i++) begin
                    if (addr_mapped(map_ptr))
                        clock_regs[map_ptr[3:0]] = rx_bytes[i];
                    map_ptr = map_ptr + 8'd1;
                    bytes_committed++;
                end
            end
        endcase
        expected_replies.push_back(reply);
    endfunction

    // predict accepted items, then check replies against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_bus_event(op_t'(s_op), s_data_in);
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply tx_byte %02h tx_valid %0b",
                             $time, m_tx_byte, m_tx_valid);
                    errors++;
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    replies_checked++;
                    if (m_tx_valid) tx_bytes_seen++;
                    if (m_tx_byte !== oldest_reply.tx_byte) begin
                        $display("%0t: tx_byte mismatch, expected %02h, got %02h",
                                 $time, oldest_reply.tx_byte, m_tx_byte);
                        errors++;
                    end
                    if (m_tx_valid !== oldest_reply.tx_valid) begin
                        $display("%0t: tx_valid mismatch, expected %0b, got %0b",
                                 $time, oldest_reply.tx_valid, m_tx_valid);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = 300;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one item from a falling edge and return at the falling edge after acceptance
    task automatic send_item(input op_t op, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_data_in <= data;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    // sender goes quiet until every predicted reply has come back
    task automatic drain_replies();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_replies.size() != 0) @(negedge aclk);
    endtask

    // mostly addresses around the map, sometimes far past it or near the wrap point
    function automatic logic [7:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 8'($urandom_range(0, MAP_LIMIT + 2));
        if (r < 85) return 8'($urandom_range(240, 255));
        return 8'($urandom);
    endfunction

    // map write from the output config address up, readback, filler and limit behavior
    task automatic test_directed_map();
        send_item(OP_TX, 8'h00);
        send_item(OP_TX, 8'hFF);
        send_item(OP_STOP, 8'h00);
        send_item(OP_START, 8'hFF);
        send_item(OP_RX, ADDR_OUT_CFG);
        send_item(OP_RX, 8'hFF);
        send_item(OP_RX, 8'h00);
        send_item(OP_RX, 8'h5A);
        send_item(OP_RX, 8'hA5);
        send_item(OP_RX, 8'h01);
        send_item(OP_RX, 8'h80);
        send_item(OP_RX, 8'h7F);
        send_item(OP_RX, 8'h12);
        send_item(OP_RX, 8'h34);
        send_item(OP_STOP, 8'hFF);
        // unmapped address below the limit still advances
        send_item(OP_TX, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_RX, ADDR_MONTH);
        send_item(OP_TX, 8'h00);
        send_item(OP_TX, 8'h00);
        send_item(OP_TX, 8'h00);
        // last address below the limit, then stuck at the limit
        send_item(OP_START, 8'h00);
        send_item(OP_RX, 8'(MAP_LIMIT - 1));
        send_item(OP_TX, 8'h00);
        send_item(OP_TX, 8'h00);
    endtask

    // write sessions, read sessions and loose events with random content
    task automatic test_random_sessions(input int n_target);
        int first;
        int pick;
        int k;
        int j;
        logic [7:0] addr;
        first = items_sent;
        while (items_sent - first < n_target) begin
            pick = $urandom_range(99);
            addr = pick_address();
            if (pick < 40) begin
                // write, occasionally past the buffer depth, sometimes stopped twice
                k = ($urandom_range(9) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 12);
                send_item(OP_START, 8'($urandom));
                send_item(OP_RX, addr);
                for (j = 0; j < k; j++) send_item(OP_RX, 8'($urandom));
                send_item(OP_STOP, 8'($urandom));
                if ($urandom_range(4) == 0) send_item(OP_STOP, 8'($urandom));
            end else if (pick < 80) begin
                // pointer set, optional repeated start, then reads
                send_item(OP_START, 8'($urandom));
                send_item(OP_RX, addr);
                if ($urandom_range(1)) send_item(OP_START, 8'($urandom));
                k = $urandom_range(1, 16);
                for (j = 0; j < k; j++) send_item(OP_TX, 8'($urandom));
                send_item(OP_STOP, 8'($urandom));
            end else begin
                k = $urandom_range(1, 6);
                for (j = 0; j < k; j++) send_item(op_t'($urandom_range(3)), 8'($urandom));
            end
        end
    endtask

    // receiver holds off while the sender keeps offering a long write and readback
    task automatic test_backpressure();
        int j;
        drain_replies();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        send_item(OP_START, 8'h00);
        send_item(OP_RX, ADDR_WAKE);
        for (j = 0; j < RX_DEPTH + 2; j++) send_item(OP_RX, 8'($urandom));
        send_item(OP_STOP, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_RX, 8'h00);
        for (j = 0; j < 20; j++) send_item(OP_TX, 8'h00);
        send_item(OP_STOP, 8'h00);
        drain_replies();
    endtask

    // main sequence
    initial begin
        int i;
        s_valid   = 1'b0;
        s_op      = OP_START;
        s_data_in = 8'h00;
        aresetn   = 1'b0;
        hold_req  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent = 0;
        replies_checked = 0;
        tx_bytes_seen = 0;
        bytes_committed = 0;
        errors = 0;
        map_ptr = '0;
        rx_fill = '0;
        for (i = 0; i < RX_DEPTH; i++) rx_bytes[i] = '0;
        for (i = 0; i < 16; i++) clock_regs[i] = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 61;
        test_directed_map();
        test_random_sessions(500);
        drain_replies();

        send_idle_pct = 61;
        recv_idle_pct = 26;
        test_random_sessions(500);
        drain_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sessions(500);
        test_backpressure();

        repeat (40) @(posedge aclk);
        if (expected_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, expected_replies.size());
            errors++;
        end
        $display("covered %0d bus events in write, read and loose sessions, %0d replies",
                 items_sent, replies_checked);
        $display("with %0d transmit bytes and %0d committed data bytes, %0d errors",
                 tx_bytes_seen, bytes_committed, errors);
        if (errors == 0) begin
            $display("i2c_target_register_map verification clean");
        end else begin
            $display("i2c_target_register_map verification failed");
        end
        $finish;
    end

endmodule
